// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: parser phases, error codes and
// the result-group structure passed from the decoder to the output stage.
// No dependencies.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
    localparam logic [2:0] ERR_UNTERM     = 3'd4;
    localparam logic [2:0] ERR_TRUNC_HEX  = 3'd5;

    localparam logic [15:0] UTF8_TWO_LIMIT  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2      = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3      = 8'hE0;
    localparam logic [7:0]  UTF8_CONT       = 8'h80;
    localparam logic [5:0]  UTF8_CONT_MASK  = 6'h3F;

    // Up to three result transfers caused by one input transfer
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            has_byte;
        logic            string_end;
        logic [2:0]      error_code;
    } grp_t;

    // Hex digit value; bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b0, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b0, 4'(c - 8'h37)};
            end else begin
                r = 5'h10;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/json_string_unescaper_unit.sv -----
// Top level of the JSON string unescaper: input register, decoder and
// output stage. Depends on jsu_pkg, jsu_decode and jsu_emit.
//
//  channel | direction | tdata            | tuser                         | tlast
//  s_      | in        | [7:0] in_char    | [0] end_of_input              | -
//  m_      | out       | [7:0] out_byte   | [0] has_byte [1] string_end   | last_of_run
//          |           |                  | [4:2] error_code              |
//
// One byte is taken per cycle while the output does not stall. A byte is
// held in the input register, its result group in the output stage. A \u escape
// that encodes to two or three UTF-8 bytes holds the input while they go out.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to idle. m_tready low stalls the output stage and then the input.
module json_string_unescaper_unit import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_char
    input  logic       s_tuser,    // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [4:0] m_tuser,    // has_byte, string_end, error_code[2:0]
    output logic       m_tlast     // last_of_run
);

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;
    grp_t       grp;
    logic       grp_ready;
    logic       item_take;
    logic       grp_load;

    assign item_take = (grp.cnt == 2'd0) || grp_ready;
    assign grp_load  = in_vld_reg && item_take && (grp.cnt != 2'd0);
    assign s_tready  = !in_vld_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    jsu_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_vld_reg),
        .item_char  (in_char_reg),
        .item_eoi   (in_eoi_reg),
        .item_take  (item_take),
        .grp        (grp)
    );

    jsu_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_in    (grp),
        .grp_load  (grp_load),
        .grp_ready (grp_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/jsu_decode.sv -----
// Decoder for the JSON string unescaper: parser state registers and the
// combinational decode of one registered byte into a result group.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  logic [7:0] item_char,
    input  logic       item_eoi,
    input  logic       item_take,
    output grp_t       grp
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;

    logic [4:0]  nib;
    logic [15:0] cp_new;
    logic        is_ws;

    assign nib    = hex_nibble(item_char);
    assign cp_new = {code_point_reg[11:0], nib[3:0]};
    assign is_ws  = (item_char == CH_SPACE) || (item_char == CH_TAB) ||
                    (item_char == CH_CR) || (item_char == CH_LF);

    always_comb begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (!item_eoi && item_char == CH_QUOTE) begin
                    phase_next = PH_STR;
                end
            end
            PH_STR: begin
                if (item_eoi || item_char == CH_QUOTE) begin
                    phase_next = PH_IDLE;
                end else if (item_char == CH_BSL) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC: begin
                if (item_eoi) begin
                    phase_next = PH_IDLE;
                end else begin
                    case (item_char)
                        "n", "t", "r", CH_QUOTE, CH_BSL, "/", "b", "f": begin
                            phase_next = PH_STR;
                        end
                        "u": begin
                            phase_next      = PH_HEX;
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (item_eoi || nib[4]) begin
                    phase_next      = PH_IDLE;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                end else if (hex_count_reg == 2'd3) begin
                    phase_next      = PH_STR;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                end else begin
                    hex_count_next  = hex_count_reg + 2'd1;
                    code_point_next = cp_new;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        grp = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (item_eoi || (!is_ws && item_char != CH_QUOTE)) begin
                    grp.cnt        = 2'd1;
                    grp.error_code = ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (item_eoi) begin
                    grp.cnt        = 2'd1;
                    grp.error_code = ERR_UNTERM;
                end else if (item_char == CH_QUOTE) begin
                    grp.cnt        = 2'd1;
                    grp.string_end = 1'b1;
                end else if (item_char != CH_BSL) begin
                    grp.cnt      = 2'd1;
                    grp.has_byte = 1'b1;
                    grp.bytes[0] = item_char;
                end
            end
            PH_ESC: begin
                grp.cnt      = 2'd1;
                grp.has_byte = 1'b1;
                if (item_eoi) begin
                    grp.has_byte   = 1'b0;
                    grp.error_code = ERR_UNTERM;
                end else begin
                    case (item_char)
                        "n":      grp.bytes[0] = 8'h0A;
                        "t":      grp.bytes[0] = 8'h09;
                        "r":      grp.bytes[0] = 8'h0D;
                        CH_QUOTE: grp.bytes[0] = 8'h22;
                        CH_BSL:   grp.bytes[0] = 8'h5C;
                        "/":      grp.bytes[0] = 8'h2F;
                        "b":      grp.bytes[0] = 8'h08;
                        "f":      grp.bytes[0] = 8'h0C;
                        "u": begin
                            grp.cnt      = 2'd0;
                            grp.has_byte = 1'b0;
                        end
                        default: begin
                            grp.has_byte   = 1'b0;
                            grp.error_code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (item_eoi) begin
                    grp.cnt        = 2'd1;
                    grp.error_code = ERR_TRUNC_HEX;
                end else if (nib[4]) begin
                    grp.cnt        = 2'd1;
                    grp.error_code = ERR_BAD_HEX;
                end else if (hex_count_reg == 2'd3) begin
                    grp.has_byte = 1'b1;
                    if (cp_new[15:7] == 9'd0) begin
                        grp.cnt      = 2'd1;
                        grp.bytes[0] = cp_new[7:0];
                    end else if (cp_new < UTF8_TWO_LIMIT) begin
                        grp.cnt      = 2'd2;
                        grp.bytes[0] = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                        grp.bytes[1] = UTF8_CONT | {2'd0, cp_new[5:0] & UTF8_CONT_MASK};
                    end else begin
                        grp.cnt      = 2'd3;
                        grp.bytes[0] = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                        grp.bytes[1] = UTF8_CONT | {2'd0, cp_new[11:6] & UTF8_CONT_MASK};
                        grp.bytes[2] = UTF8_CONT | {2'd0, cp_new[5:0] & UTF8_CONT_MASK};
                    end
                end
            end
            default: begin
                grp = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
        end else if (item_valid && item_take) begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

    a_hex_count_only_in_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        (hex_count_reg != 2'd0) |-> (phase_reg == PH_HEX))
        else $error("hex digit count set outside a \\u escape");

    a_cp_clear_outside_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HEX) |-> (code_point_reg == 16'd0))
        else $error("code point not cleared outside a \\u escape");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_valid && item_take) |=> $stable(phase_reg))
        else $error("parser phase moved without a transfer");

endmodule

// ----- rtl/jsu_emit.sv -----
// Output stage of the JSON string unescaper: holds one result group and
// sends its one to three entries as separate transfers on the result channel.
// Depends on jsu_pkg.
module jsu_emit import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  grp_t       grp_in,
    input  logic       grp_load,
    output logic       grp_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [4:0] m_tuser,    // has_byte, string_end, error_code[2:0]
    output logic       m_tlast     // last_of_run
);

    grp_t       grp_reg;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] cnt_next;
    logic       last_beat;

    assign m_tvalid  = (grp_reg.cnt != 2'd0);
    assign last_beat = (idx_reg == grp_reg.cnt - 2'd1);
    assign m_tlast   = last_beat;
    assign m_tdata   = grp_reg.bytes[idx_reg];
    assign m_tuser   = {grp_reg.error_code, grp_reg.string_end, grp_reg.has_byte};
    assign grp_ready = !m_tvalid || (m_tready && last_beat);

    always_comb begin
        cnt_next = grp_reg.cnt;
        idx_next = idx_reg;
        if (grp_load) begin
            cnt_next = grp_in.cnt;
            idx_next = 2'd0;
        end else if (m_tvalid && m_tready) begin
            if (last_beat) begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg.cnt <= 2'd0;
            idx_reg     <= 2'd0;
        end else begin
            grp_reg.cnt <= cnt_next;
            idx_reg     <= idx_next;
            if (grp_load) begin
                grp_reg.bytes      <= grp_in.bytes;
                grp_reg.has_byte   <= grp_in.has_byte;
                grp_reg.string_end <= grp_in.string_end;
                grp_reg.error_code <= grp_in.error_code;
            end
        end
    end

    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < grp_reg.cnt))
        else $error("byte index beyond result group");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && grp_reg.error_code != ERR_NONE) |->
            (m_tlast && !grp_reg.has_byte && !grp_reg.string_end))
        else $error("error result not a lone transfer");

    a_no_load_mid_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (grp_load && m_tvalid) |-> (m_tready && last_beat))
        else $error("new group loaded over pending bytes");

endmodule

// ----- tb/json_string_unescaper_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescaper_unit: a queued byte driver, a result
// monitor and an in-bench decoder that predicts every result transfer.
// Depends on jsu_pkg and the unit under test.
module json_string_unescaper_unit_test;
    import jsu_pkg::*;

    localparam int         N_CHARS   = 270;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } text_char_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
        logic [2:0] err;
        logic       last;
    } decoded_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    text_char_t text_q[$];
    decoded_t   decoded_q[$];
    text_char_t next_char;
    decoded_t   want;
    string      esc_letters = "ntr\"\\/bf";

    phase_t      ps_phase;
    logic [1:0]  ps_count;
    logic [15:0] ps_code;

    int   chars_taken;
    int   fails;
    int   hold_left;
    logic hold_done;
    logic in_fire;
    logic calm;

    assign calm = chars_taken >= 150 && chars_taken < 220;

    json_string_unescaper_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
    endfunction

    function automatic int hex_val(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
        if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
        return -1;
    endfunction

    function automatic decoded_t mk(input logic [7:0] data, input logic has, input logic fin,
                                    input logic [2:0] err);
        return '{data: data, has: has, fin: fin, err: err, last: 1'b0};
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic eoi);
        decoded_t    grp[3];
        int          n;
        int          nv;
        logic        esc_ok;
        logic [7:0]  lit;
        logic [2:0]  fault;
        logic [15:0] cp;
        n = 0;
        fault = ERR_NONE;
        case (ps_phase)
            PH_IDLE: begin
                if (eoi) fault = ERR_NO_QUOTE;
                else if (ch == CH_QUOTE) ps_phase = PH_STR;
                else if (!is_space(ch)) fault = ERR_NO_QUOTE;
            end
            PH_STR: begin
                if (eoi) begin
                    fault = ERR_UNTERM;
                end else if (ch == CH_BSLASH) begin
                    ps_phase = PH_ESC;
                end else if (ch == CH_QUOTE) begin
                    ps_phase = PH_IDLE;
                    grp[0] = mk(8'h00, 1'b0, 1'b1, ERR_NONE);
                    n = 1;
                end else begin
                    grp[0] = mk(ch, 1'b1, 1'b0, ERR_NONE);
                    n = 1;
                end
            end
            PH_ESC: begin
                if (eoi) begin
                    fault = ERR_UNTERM;
                end else begin
                    ps_phase = PH_STR;
                    esc_ok = 1'b1;
                    lit = ch;
                    case (ch)
                        "n": lit = CH_LF;
                        "t": lit = CH_TAB;
                        "r": lit = CH_CR;
                        "b": lit = 8'h08;
                        "f": lit = 8'h0C;
                        CH_QUOTE, CH_BSLASH, "/": lit = ch;
                        "u": begin
                            esc_ok = 1'b0;
                            ps_phase = PH_HEX;
                            ps_count = 2'd0;
                            ps_code = 16'h0000;
                        end
                        default: begin
                            esc_ok = 1'b0;
                            fault = ERR_BAD_ESCAPE;
                        end
                    endcase
                    if (esc_ok) begin
                        grp[0] = mk(lit, 1'b1, 1'b0, ERR_NONE);
                        n = 1;
                    end
                end
            end
            default: begin
                nv = hex_val(ch);
                if (eoi) begin
                    fault = ERR_TRUNC_HEX;
                end else if (nv < 0) begin
                    fault = ERR_BAD_HEX;
                end else begin
                    cp = {ps_code[11:0], 4'(nv)};
                    if (ps_count == 2'd3) begin
                        ps_phase = PH_STR;
                        ps_count = 2'd0;
                        ps_code = 16'h0000;
                        if (cp < 16'h0080) begin
                            grp[0] = mk(cp[7:0], 1'b1, 1'b0, ERR_NONE);
                            n = 1;
                        end else if (cp < UTF8_TWO_LIMIT) begin
                            grp[0] = mk(UTF8_LEAD2 | {3'b0, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
                            grp[1] = mk(UTF8_CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
                            n = 2;
                        end else begin
                            grp[0] = mk(UTF8_LEAD3 | {4'b0, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
                            grp[1] = mk(UTF8_CONT | {2'b0, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
                            grp[2] = mk(UTF8_CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
                            n = 3;
                        end
                    end else begin
                        ps_code = cp;
                        ps_count = ps_count + 2'd1;
                    end
                end
            end
        endcase
        if (fault != ERR_NONE) begin
            ps_phase = PH_IDLE;
            ps_count = 2'd0;
            ps_code = 16'h0000;
            grp[0] = mk(8'h00, 1'b0, 1'b0, fault);
            n = 1;
        end
        if (n > 0) grp[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), grp[i]);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // Stimulus builders
    function automatic void put_ch(input logic [7:0] ch, input logic eoi = 1'b0);
        text_q.insert(text_q.size(), text_char_t'{ch: ch, eoi: eoi});
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(int'("0") + v);
        return 8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + v - 10);
    endfunction

    function automatic logic is_escape(input logic [7:0] ch);
        for (int i = 0; i < 8; i++) begin
            if (esc_letters[i] == ch) return 1'b1;
        end
        return ch == "u";
    endfunction

    function automatic logic [15:0] rand_code();
        case ($urandom_range(0, 2))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    function automatic void put_hex(input logic [15:0] cp, input int digits);
        put_ch(CH_BSLASH);
        put_ch("u");
        for (int i = 0; i < digits; i++) put_ch(hex_char(int'(cp[15 - 4 * i -: 4])));
    endfunction

    function automatic void put_open();
        logic [7:0] ws[4];
        ws = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        repeat ($urandom_range(0, 2)) put_ch(ws[$urandom_range(0, 3)]);
        put_ch(CH_QUOTE);
    endfunction

    function automatic void put_elem();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            6, 7: begin
                put_ch(CH_BSLASH);
                put_ch(esc_letters[$urandom_range(0, 7)]);
            end
            8, 9: put_hex(rand_code(), 4);
            default: begin
                do c = rand_byte(); while (c == CH_QUOTE || c == CH_BSLASH);
                put_ch(c);
            end
        endcase
    endfunction

    // Input side and result checking
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            decode_char(s_tdata, s_tuser);
            chars_taken <= chars_taken + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result: data 0x%0h user 0x%0h last %0b",
                       m_tdata, m_tuser, m_tlast);
                fails++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("has_byte", want.has, m_tuser[0]);
                check_field("string_end", want.fin, m_tuser[1]);
                check_field("error_code", want.err, m_tuser[4:2]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    // Byte driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
                next_char = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.ch;
                s_tuser  <= next_char.eoi;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver; one long hold-off to back the unit up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && chars_taken >= 60) begin
            m_tready  <= 1'b0;
            hold_left <= 40;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 21;
        end
    end

    initial begin
        int         sel;
        int         n_chars;
        int         drain;
        logic [7:0] c;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        in_fire     = 1'b0;
        chars_taken = 0;
        fails       = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        ps_phase    = PH_IDLE;
        ps_count    = 2'd0;
        ps_code     = 16'h0000;

        put_ch(8'h00, 1'b1);
        put_ch("x");
        put_ch(CH_SPACE);
        put_ch(CH_TAB);
        put_ch(CH_CR);
        put_ch(CH_LF);
        put_ch(CH_QUOTE);
        put_ch(8'h00);
        put_ch(8'hFF);
        put_ch(CH_BSLASH);
        put_ch("q");
        put_ch(CH_QUOTE);
        put_ch(CH_BSLASH);
        put_ch("u");
        put_ch("F");
        put_ch("f");
        put_ch("F");
        put_ch("F");
        put_ch(CH_BSLASH);
        put_ch("u");
        put_ch("g");
        put_ch(CH_QUOTE);
        put_hex(16'h0000, 1);
        put_ch(8'h00, 1'b1);
        put_ch(CH_QUOTE);
        put_ch(CH_BSLASH);
        put_ch(8'hFF, 1'b1);

        while (text_q.size() < N_CHARS) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                put_open();
                repeat ($urandom_range(0, 6)) put_elem();
                if (sel < 62) begin
                    put_ch(CH_QUOTE);
                    if ($urandom_range(0, 9) == 0) put_ch(rand_byte(), 1'b1);
                end else begin
                    case (sel % 5)
                        0: put_ch(rand_byte(), 1'b1);
                        1: begin
                            put_ch(CH_BSLASH);
                            do c = rand_byte(); while (is_escape(c));
                            put_ch(c);
                        end
                        2: begin
                            put_ch(CH_BSLASH);
                            put_ch(rand_byte(), 1'b1);
                        end
                        3: begin
                            put_hex(rand_code(), $urandom_range(0, 3));
                            do c = rand_byte(); while (hex_val(c) >= 0);
                            put_ch(c);
                        end
                        default: begin
                            put_hex(rand_code(), $urandom_range(0, 3));
                            put_ch(rand_byte(), 1'b1);
                        end
                    endcase
                end
            end else if (sel < 90) begin
                do c = rand_byte(); while (c == CH_QUOTE || is_space(c));
                put_ch(c);
            end else begin
                put_ch(rand_byte(), 1'b1);
            end
        end
        n_chars = text_q.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (chars_taken != n_chars) @(negedge aclk);
        drain = 0;
        while (decoded_q.size() != 0 && drain < 2000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (10) @(negedge aclk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected results never arrived", decoded_q.size());
            fails++;
        end
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescaper_unit.sv
tb/json_string_unescaper_unit_test.sv
